@@ src/cvts_pkg.sv @@
// ----------------------------------------------------------------------------
// cvts_pkg
// shared widths, codes, states and the partial statistics record that
// travels along the cell chain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cvts_pkg;

    localparam int CELL_W = 13;   // cell voltage in millivolts
    localparam int TEMP_W = 12;   // temperature in tenths of a degree
    localparam int SLOT_W = 4;    // slot index of one request
    localparam int CNT_W  = 5;    // count of cells, up to sixteen
    localparam int SUM_W  = 17;   // sum of up to sixteen cell voltages
    localparam int REG_W  = 2;    // configuration register index
    localparam int CFG_W  = 13;   // configuration write data
    localparam int ACT_W  = 4;    // active cell count field
    localparam int SEL_W  = 2;    // sensor select field

    // request types
    localparam logic REQ_CELL = 1'b0;
    localparam logic REQ_TEMP = 1'b1;

    // configuration register indexes
    localparam logic [REG_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [REG_W-1:0] REG_ACTIVE    = 2'd1;
    localparam logic [REG_W-1:0] REG_SENSOR    = 2'd2;

    // sensor select codes, the unused code behaves as both
    localparam logic [SEL_W-1:0] SEL_BOTH = 2'd0;
    localparam logic [SEL_W-1:0] SEL_S0   = 2'd1;
    localparam logic [SEL_W-1:0] SEL_S1   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DIV,
        ST_LOAD
    } t_state;

    // partial statistics handed from one cell to the next
    typedef struct packed {
        logic              valid;
        logic [CNT_W-1:0]  cnt;
        logic [CELL_W-1:0] lo;
        logic [CELL_W-1:0] hi;
        logic [SUM_W-1:0]  sum;
    } t_acc;

endpackage

@@ src/cell_voltage_temp_statistics.sv @@
// ----------------------------------------------------------------------------
// cell_voltage_temp_statistics
// cell voltage and temperature statistics for one battery module
// ----------------------------------------------------------------------------
// Each input beat writes one cell voltage or one temperature and yields one
// output beat with the cell minimum, maximum and truncated mean (over cells
// below the active count whose voltage is strictly above the ignore
// threshold, all zero when none qualifies) and the low, high and average
// temperature per the sensor select. The partial statistics walk the row of
// cells one cell per cycle, then the mean comes from a divider that produces
// one quotient bit per cycle over 17 bits. One item is in work at a time; the
// output register holds a finished beat while the next input beat is taken.
// Configuration writes are always ready and are meant for idle time only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cell_voltage_temp_statistics #(
    parameter int MAX_CELLS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_req_type,
    input  logic [cvts_pkg::SLOT_W-1:0]       i_slot_index,
    input  logic [cvts_pkg::CELL_W-1:0]       i_cell_mv,
    input  logic signed [cvts_pkg::TEMP_W-1:0] i_temp_deci_c,
    // output channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [cvts_pkg::CELL_W-1:0]       o_low_cell_mv,
    output logic [cvts_pkg::CELL_W-1:0]       o_high_cell_mv,
    output logic [cvts_pkg::CELL_W-1:0]       o_avg_cell_mv,
    output logic signed [cvts_pkg::TEMP_W-1:0] o_low_temp,
    output logic signed [cvts_pkg::TEMP_W-1:0] o_high_temp,
    output logic signed [cvts_pkg::TEMP_W-1:0] o_avg_temp,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cvts_pkg::REG_W-1:0]        i_cfg_index,
    input  logic [cvts_pkg::CFG_W-1:0]        i_cfg_data
);
    import cvts_pkg::*;

    // state
    t_state r_state;
    t_state n_state;

    // configuration
    logic [CELL_W-1:0] r_threshold;
    logic [CNT_W-1:0]  r_active;
    logic [SEL_W-1:0]  r_sel;
    logic [CNT_W-1:0]  w_act_req;

    // temperature store
    logic signed [TEMP_W-1:0] r_temp0;
    logic signed [TEMP_W-1:0] r_temp1;

    // sweep and divide
    logic              w_accept;
    logic              r_go;
    t_acc              w_seed;
    t_acc              w_chain [MAX_CELLS];
    t_acc              w_last;
    logic              w_sweep_done;
    logic [CELL_W-1:0] r_lo;
    logic [CELL_W-1:0] r_hi;
    logic              r_none;
    logic [CELL_W-1:0] r_avg;
    logic              w_div_done;
    logic [SUM_W-1:0]  w_quot;
    logic              w_load;

    // output register
    logic                     r_out_valid;
    logic [CELL_W-1:0]        r_low_cell;
    logic [CELL_W-1:0]        r_high_cell;
    logic [CELL_W-1:0]        r_avg_cell;
    logic signed [TEMP_W-1:0] r_low_temp;
    logic signed [TEMP_W-1:0] r_high_temp;
    logic signed [TEMP_W-1:0] r_avg_temp;

    // temperature results
    logic signed [TEMP_W-1:0] w_tlo;
    logic signed [TEMP_W-1:0] w_thi;
    logic signed [TEMP_W-1:0] w_tavg;
    logic signed [TEMP_W:0]   w_tsum;

    assign o_stall  = (r_state != ST_IDLE);
    assign w_accept = i_valid && !o_stall;

    // ------------------------------------------------------------------
    // configuration registers, always ready
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;
    assign w_act_req   = {1'b0, i_cfg_data[ACT_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_active    <= CNT_W'(MAX_CELLS);
            r_sel       <= SEL_BOTH;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_THRESHOLD: r_threshold <= i_cfg_data[CELL_W-1:0];
                REG_ACTIVE: begin
                    // zero or more cells than built falls back to all cells
                    if (w_act_req == '0 || w_act_req > CNT_W'(MAX_CELLS)) begin
                        r_active <= CNT_W'(MAX_CELLS);
                    end else begin
                        r_active <= w_act_req;
                    end
                end
                REG_SENSOR: r_sel <= i_cfg_data[SEL_W-1:0];
                default: ;  // unknown register, no effect
            endcase
        end
    end

    // ------------------------------------------------------------------
    // temperature store, out-of-range sensor numbers are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp0 <= '0;
            r_temp1 <= '0;
        end else if (w_accept && i_req_type == REQ_TEMP) begin
            if (i_slot_index == SLOT_W'(0)) begin
                r_temp0 <= i_temp_deci_c;
            end else if (i_slot_index == SLOT_W'(1)) begin
                r_temp1 <= i_temp_deci_c;
            end
        end
    end

    // ------------------------------------------------------------------
    // cell chain: a token enters cell 0 the cycle after the write and
    // picks up one cell per cycle; writes beyond the row match no cell
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go <= 1'b0;
        end else begin
            r_go <= w_accept;
        end
    end

    always_comb begin
        w_seed       = '0;
        w_seed.valid = r_go;
    end

    for (genvar g = 0; g < MAX_CELLS; g++) begin : g_cell
        t_acc w_in;
        if (g == 0) begin : g_head
            assign w_in = w_seed;
        end else begin : g_link
            assign w_in = w_chain[g-1];
        end
        cvts_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_wr_en     (w_accept && i_req_type == REQ_CELL),
            .i_slot      (i_slot_index),
            .i_mv        (i_cell_mv),
            .i_threshold (r_threshold),
            .i_active    (r_active),
            .i_acc       (w_in),
            .o_acc       (w_chain[g])
        );
    end

    assign w_last       = w_chain[MAX_CELLS-1];
    assign w_sweep_done = (r_state == ST_SWEEP) && w_last.valid;

    // min and max start at zero, so an empty sweep already reads zero
    always_ff @(posedge i_clk) begin
        if (w_sweep_done) begin
            r_lo   <= w_last.lo;
            r_hi   <= w_last.hi;
            r_none <= (w_last.cnt == '0);
        end
        if (w_div_done) begin
            r_avg <= r_none ? '0 : w_quot[CELL_W-1:0];
        end
    end

    cvts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sweep_done),
        .i_dividend (w_last.sum),
        .i_divisor  (w_last.cnt),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // ------------------------------------------------------------------
    // temperature statistics, read from the store at load time
    // ------------------------------------------------------------------
    assign w_tsum = {r_temp0[TEMP_W-1], r_temp0} + {r_temp1[TEMP_W-1], r_temp1};

    always_comb begin
        unique case (r_sel)
            SEL_S0: begin
                w_tlo  = r_temp0;
                w_thi  = r_temp0;
                w_tavg = r_temp0;
            end
            SEL_S1: begin
                w_tlo  = r_temp1;
                w_thi  = r_temp1;
                w_tavg = r_temp1;
            end
            default: begin
                // both sensors, also the unused code
                w_tlo  = (r_temp0 < r_temp1) ? r_temp0 : r_temp1;
                w_thi  = (r_temp0 > r_temp1) ? r_temp0 : r_temp1;
                w_tavg = w_tsum[TEMP_W:1];  // arithmetic halving floors
            end
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (w_last.valid) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                // wait for room in the output register
                if (!r_out_valid || !i_stall) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_low_cell  <= r_lo;
            r_high_cell <= r_hi;
            r_avg_cell  <= r_avg;
            r_low_temp  <= w_tlo;
            r_high_temp <= w_thi;
            r_avg_temp  <= w_tavg;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_low_cell_mv  = r_low_cell;
    assign o_high_cell_mv = r_high_cell;
    assign o_avg_cell_mv  = r_avg_cell;
    assign o_low_temp     = r_low_temp;
    assign o_high_temp    = r_high_temp;
    assign o_avg_temp     = r_avg_temp;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_accept_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_SWEEP && r_go))
        else $error("accepted beat did not start a sweep");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide phase");

    a_cell_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_low_cell_mv <= o_avg_cell_mv && o_avg_cell_mv <= o_high_cell_mv))
        else $error("cell average outside min and max");

    a_temp_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_low_temp <= o_avg_temp && o_avg_temp <= o_high_temp))
        else $error("temperature average outside low and high");

    a_load_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (o_valid && !o_stall))
        else $error("loaded beat not shown or input not reopened");

endmodule

@@ src/cvts_cell.sv @@
// ----------------------------------------------------------------------------
// cvts_cell
// one cell of the chain: holds one cell voltage and folds it into the
// partial statistics passing by
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cvts_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic [cvts_pkg::SLOT_W-1:0] i_slot,
    input  logic [cvts_pkg::CELL_W-1:0] i_mv,
    input  logic [cvts_pkg::CELL_W-1:0] i_threshold,
    input  logic [cvts_pkg::CNT_W-1:0]  i_active,
    input  cvts_pkg::t_acc             i_acc,
    output cvts_pkg::t_acc             o_acc
);
    import cvts_pkg::*;

    logic [CELL_W-1:0] r_mv;
    t_acc              r_acc;
    t_acc              n_acc;
    logic              w_qual;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= '0;
        end else if (i_wr_en && i_slot == SLOT_W'(CELL_IDX)) begin
            r_mv <= i_mv;
        end
    end

    assign w_qual = (CNT_W'(CELL_IDX) < i_active) && (r_mv > i_threshold);

    always_comb begin
        n_acc = i_acc;
        if (w_qual) begin
            n_acc.cnt = i_acc.cnt + CNT_W'(1);
            n_acc.sum = i_acc.sum + SUM_W'(r_mv);
            if (i_acc.cnt == '0 || r_mv < i_acc.lo) begin
                n_acc.lo = r_mv;
            end
            if (i_acc.cnt == '0 || r_mv > i_acc.hi) begin
                n_acc.hi = r_mv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc.valid <= 1'b0;
        end else begin
            r_acc.valid <= i_acc.valid;
        end
        r_acc.cnt <= n_acc.cnt;
        r_acc.lo  <= n_acc.lo;
        r_acc.hi  <= n_acc.hi;
        r_acc.sum <= n_acc.sum;
    end

    assign o_acc = r_acc;

endmodule

@@ src/cvts_div.sv @@
// ----------------------------------------------------------------------------
// cvts_div
// restoring divider, one quotient bit per cycle, for sum over count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cvts_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [cvts_pkg::SUM_W-1:0] i_dividend,
    input  logic [cvts_pkg::CNT_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [cvts_pkg::SUM_W-1:0] o_quot
);
    import cvts_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [SUM_W-1:0]  r_dvd;     // dividend shifts out, quotient shifts in
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_dvs;
    logic [CNT_W:0]    w_trial;
    logic              w_qbit;
    logic [CNT_W-1:0]  w_rem_next;

    assign w_trial    = {r_rem, r_dvd[SUM_W-1]};
    assign w_qbit     = w_trial >= {1'b0, r_dvs};
    // remainder stays below the divisor, so it fits CNT_W bits
    assign w_rem_next = w_qbit ? CNT_W'(w_trial - {1'b0, r_dvs}) : CNT_W'(w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
                r_rem  <= '0;
                r_step <= '0;
            end else if (r_busy) begin
                r_rem  <= w_rem_next;
                r_dvd  <= {r_dvd[SUM_W-2:0], w_qbit};
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;

endmodule
